// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the stencil RTL.
// Both expect a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define S3D_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// An implication: when ante holds, cons must follow (cons may carry a delay).
`define S3D_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/s3d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package s3d_pkg;

  // Field widths of the item channels and the size registers.
  localparam int SAMPLE_W = 32;
  localparam int POS_W    = 6;
  localparam int CFG_W    = 7;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // Default grid capacity per axis.
  localparam int DEF_MAX_I = 64;
  localparam int DEF_MAX_J = 64;
  localparam int DEF_MAX_K = 64;

  // Width for comparing coordinates against sizes; covers extents up to 1024 plus margin.
  localparam int CMP_W = 12;

  // Result queue depth; must exceed the number of items the pipeline holds.
  localparam int OUT_DEPTH = 8;

  // Effective grid sizes and the restart strobe from the register block.
  typedef struct packed {
    logic [CFG_W-1:0] n_i;
    logic [CFG_W-1:0] n_j;
    logic [CFG_W-1:0] n_k;
    logic             restart;
  } s3d_cfg_t;

  // The seven stencil operands of one point.
  typedef struct packed {
    logic [SAMPLE_W-1:0] center;
    logic [SAMPLE_W-1:0] i_lo;
    logic [SAMPLE_W-1:0] i_hi;
    logic [SAMPLE_W-1:0] j_lo;
    logic [SAMPLE_W-1:0] j_hi;
    logic [SAMPLE_W-1:0] k_lo;
    logic [SAMPLE_W-1:0] k_hi;
  } s3d_ops_t;

  // Position tag that travels with a point through the pipeline.
  typedef struct packed {
    logic [POS_W-1:0] pos_i;
    logic [POS_W-1:0] pos_j;
    logic [POS_W-1:0] pos_k;
    logic             last_point;
  } s3d_meta_t;

  // One finished result item.
  typedef struct packed {
    logic [SAMPLE_W-1:0] result;
    logic [POS_W-1:0]    pos_i;
    logic [POS_W-1:0]    pos_j;
    logic [POS_W-1:0]    pos_k;
    logic                last_point;
  } s3d_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/s3d_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel carrying grid samples.
interface s3d_sample_if;
  import s3d_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// Channel carrying updated interior points.
interface s3d_result_if;
  import s3d_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] result;
  logic [POS_W-1:0]           pos_i;
  logic [POS_W-1:0]           pos_j;
  logic [POS_W-1:0]           pos_k;
  logic                       last_point;

  modport source (output valid, output result, output pos_i, output pos_j, output pos_k,
                  output last_point, input ready);
  modport sink (input valid, input result, input pos_i, input pos_j, input pos_k,
                input last_point, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/s3d_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module s3d_cfg_regs #(
  parameter int MAX_I = s3d_pkg::DEF_MAX_I,
  parameter int MAX_J = s3d_pkg::DEF_MAX_J,
  parameter int MAX_K = s3d_pkg::DEF_MAX_K
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [s3d_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [s3d_pkg::PDATA_W-1:0]   pwdata,
  output logic      [s3d_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output s3d_pkg::s3d_cfg_t                  cfg
);
  import s3d_pkg::*;

  localparam int IDX_W = PADDR_W - 2;
  localparam logic [IDX_W-1:0] REG_SIZE_I = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SIZE_J = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_SIZE_K = IDX_W'(2);
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] MIN_SIZE   = CFG_W'(3);

  logic [CFG_W-1:0] size_i;
  logic [CFG_W-1:0] size_j;
  logic [CFG_W-1:0] size_k;
  logic [IDX_W-1:0] reg_idx;
  logic             wr;

  // Clamp a programmed size into the range the line stores support.
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] r,
                                                  input int max_v);
    logic [CFG_W-1:0] v;
    v = r;
    if (r < MIN_SIZE) begin
      v = MIN_SIZE;
    end else if (int'(r) > max_v) begin
      v = CFG_W'(max_v);
    end
    return v;
  endfunction

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Size registers; a write to any of them starts a new grid.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_i <= SIZE_RESET;
      size_j <= SIZE_RESET;
      size_k <= SIZE_RESET;
    end else if (wr) begin
      case (reg_idx)
        REG_SIZE_I: size_i <= pwdata[CFG_W-1:0];
        REG_SIZE_J: size_j <= pwdata[CFG_W-1:0];
        REG_SIZE_K: size_k <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      REG_SIZE_I: prdata = PDATA_W'(size_i);
      REG_SIZE_J: prdata = PDATA_W'(size_j);
      REG_SIZE_K: prdata = PDATA_W'(size_k);
      default:    prdata = '0;
    endcase
  end

  // Effective sizes and restart strobe.
  always_comb begin
    cfg.n_i     = clamp_size(size_i, MAX_I);
    cfg.n_j     = clamp_size(size_j, MAX_J);
    cfg.n_k     = clamp_size(size_k, MAX_K);
    cfg.restart = wr && (reg_idx == REG_SIZE_I || reg_idx == REG_SIZE_J ||
                         reg_idx == REG_SIZE_K);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/s3d_plane_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module s3d_plane_mem #(
  parameter int AW = 13,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr0,
  input  wire logic [AW-1:0] raddr1,
  output logic      [DW-1:0] rdata0,
  output logic      [DW-1:0] rdata1
);
  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] store [0:DEPTH-1];

  // One write and two registered reads per cycle; a read of the entry being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= store[raddr0];
      rdata1 <= store[raddr1];
    end
    if (we) begin
      store[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/s3d_stencil_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

module s3d_stencil_pipe (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire s3d_pkg::s3d_ops_t    ops,
  input  wire s3d_pkg::s3d_meta_t   meta,
  output logic                      out_valid,
  output s3d_pkg::s3d_res_t         out_item
);
  import s3d_pkg::*;

  localparam int SUM_W = SAMPLE_W + 3;  // six 32-bit terms
  localparam int DIF_W = SAMPLE_W + 4;  // sum minus six times the center
  localparam int MAG_W = DIF_W - 1;
  localparam int X_W   = MAG_W - 1;     // magnitude halved
  localparam int XL_W  = 17;
  localparam int XH_W  = X_W - XL_W;
  localparam int PH_W  = 33;
  localparam int Y_W   = 19;
  localparam int PL_W  = 37;
  localparam int Q_W   = X_W;
  localparam int R_W   = 36;

  // 2^17 = 3 * 43690 + 2, and 174763 = (2^19 + 1) / 3 gives an exact
  // divide by three for values below 2^19.
  localparam logic [15:0] DIV3_HI = 16'd43690;
  localparam logic [17:0] RECIP3  = 18'd174763;

  localparam logic signed [R_W-1:0] SAT_HI = 36'sh0_7FFF_FFFF;
  localparam logic signed [R_W-1:0] SAT_LO = 36'shF_8000_0000;

  logic signed [SUM_W-1:0] sum6;
  logic signed [DIF_W-1:0] diff;
  logic [X_W-1:0]          x;
  logic [Y_W-1:0]          y;
  logic signed [R_W-1:0]   c_ext;
  logic signed [R_W-1:0]   q_ext;
  logic signed [R_W-1:0]   r;

  logic                      v2, v3, v4, v5;
  logic signed [SUM_W-1:0]   sum_s2;
  logic [SAMPLE_W-1:0]       c_s2, c_s3, c_s4, c_s5;
  s3d_meta_t                 m_s2, m_s3, m_s4, m_s5;
  logic [MAG_W-1:0]          mag_s3;
  logic                      neg_s3, neg_s4, neg_s5;
  logic [PH_W-1:0]           ph_s4;
  logic [PL_W-1:0]           pl_s4;
  logic [Q_W-1:0]            q_s5;

  // Stage 1: sum of the six neighbors.
  assign sum6 = SUM_W'($signed(ops.i_lo)) + SUM_W'($signed(ops.i_hi)) +
                SUM_W'($signed(ops.j_lo)) + SUM_W'($signed(ops.j_hi)) +
                SUM_W'($signed(ops.k_lo)) + SUM_W'($signed(ops.k_hi));

  // Stage 2: subtract six times the center and take the magnitude.
  assign diff = DIF_W'(sum_s2) - (DIF_W'($signed(c_s2)) <<< 2) -
                (DIF_W'($signed(c_s2)) <<< 1);

  // Stage 3: halve, then split for the divide by three.
  assign x = mag_s3[MAG_W-1:1];
  assign y = Y_W'({x[X_W-1:XL_W], 1'b0}) + Y_W'(x[XL_W-1:0]);

  // Stage 5: apply the sign, add the center, saturate.
  assign c_ext = R_W'($signed(c_s5));
  assign q_ext = $signed(R_W'(q_s5));
  assign r     = neg_s5 ? (c_ext - q_ext) : (c_ext + q_ext);

  always_comb begin
    out_valid           = v5;
    out_item.pos_i      = m_s5.pos_i;
    out_item.pos_j      = m_s5.pos_j;
    out_item.pos_k      = m_s5.pos_k;
    out_item.last_point = m_s5.last_point;
    if (r > SAT_HI) begin
      out_item.result = SAT_HI[SAMPLE_W-1:0];
    end else if (r < SAT_LO) begin
      out_item.result = SAT_LO[SAMPLE_W-1:0];
    end else begin
      out_item.result = r[SAMPLE_W-1:0];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v2 <= in_valid;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    sum_s2 <= sum6;
    c_s2   <= ops.center;
    m_s2   <= meta;

    mag_s3 <= diff[DIF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    neg_s3 <= diff[DIF_W-1];
    c_s3   <= c_s2;
    m_s3   <= m_s2;

    ph_s4  <= PH_W'(x[X_W-1:XL_W]) * PH_W'(DIV3_HI);
    pl_s4  <= PL_W'(y) * PL_W'(RECIP3);
    neg_s4 <= neg_s3;
    c_s4   <= c_s3;
    m_s4   <= m_s3;

    q_s5   <= Q_W'(ph_s4) + Q_W'(pl_s4[PL_W-1:Y_W]);
    neg_s5 <= neg_s4;
    c_s5   <= c_s4;
    m_s5   <= m_s4;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/s3d_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module s3d_out_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           reserve,
  input  wire logic           push,
  input  wire s3d_pkg::s3d_res_t push_item,
  output logic                can_reserve,
  s3d_result_if.source        res
);
  import s3d_pkg::*;

  localparam int PW  = $clog2(OUT_DEPTH);
  localparam int CNW = $clog2(OUT_DEPTH + 1);

  s3d_res_t       slots [0:OUT_DEPTH-1];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CNW-1:0] count;
  logic [CNW-1:0] credit;
  logic           pop;
  s3d_res_t       head;

  assign pop         = res.valid && res.ready;
  assign can_reserve = credit < CNW'(OUT_DEPTH);
  assign head        = slots[rd_ptr];

  assign res.valid      = count != '0;
  assign res.result     = head.result;
  assign res.pos_i      = head.pos_i;
  assign res.pos_j      = head.pos_j;
  assign res.pos_k      = head.pos_k;
  assign res.last_point = head.last_point;

  // Pointers, fill count and the credit count of slots promised to items in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      credit <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(OUT_DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(OUT_DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNW'(count - 1'b1);
      end
      if (reserve && !pop) begin
        credit <= CNW'(credit + 1'b1);
      end else if (pop && !reserve) begin
        credit <= CNW'(credit - 1'b1);
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `S3D_ASSERT_ALWAYS(a_count_within_credit, count <= credit, "queue holds an unreserved item")
  `S3D_ASSERT_IMP(a_push_has_room, push, count < CNW'(OUT_DEPTH), "push into a full queue")

endmodule

`default_nettype wire

// ===== hw/rtl/stencil_3d_seven_point.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Seven-point 3D Jacobi stencil over a streamed grid of signed Q8.24 samples.
// Samples enter on the samples channel in raster order (k fastest, then j,
// then i). While samples.ready is high, each item may be followed by the next
// one in the following cycle, so the block sustains one sample per cycle. For
// every interior point the block returns center + trunc((six neighbors -
// 6*center) / 6), saturated, on the results channel with its coordinates;
// last_point marks the final interior point of the grid. Border points give no result.
// A result becomes available once the sample that completes its neighborhood is
// accepted and has passed a memory read, four arithmetic stages and the queue.
// The last two planes live in two copies of a plane memory, each with one
// write and two read ports; together they serve the four reads a sample needs.
// A result queue of 8 items absorbs a stalled receiver; the samples channel
// drops ready once every queue slot is promised to a point in flight.
// The size registers are on the APB port; any size write restarts the grid.
// Reset restores all sizes to 64 and the coordinates to zero; plane memory
// contents are not cleared and no clearing pass runs.
module stencil_3d_seven_point #(
  parameter int MAX_I = s3d_pkg::DEF_MAX_I,
  parameter int MAX_J = s3d_pkg::DEF_MAX_J,
  parameter int MAX_K = s3d_pkg::DEF_MAX_K
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  s3d_sample_if.sink                        samples,
  s3d_result_if.source                      results,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [s3d_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [s3d_pkg::PDATA_W-1:0]  pwdata,
  output logic      [s3d_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);
  import s3d_pkg::*;

  localparam int IW = $clog2(MAX_I);
  localparam int JW = $clog2(MAX_J);
  localparam int KW = $clog2(MAX_K);
  localparam int AW = 1 + JW + KW;

  s3d_cfg_t            cfg;
  logic [IW-1:0]       cnt_i, i_next;
  logic [JW-1:0]       cnt_j, j_next;
  logic [KW-1:0]       cnt_k, k_next;
  logic [CMP_W-1:0]    ci, cj, ck, ni, nj, nk;
  logic                accept;
  logic                emit;
  logic                k_end, j_end, i_end;
  logic                can_reserve;
  logic                cur_pl, prev_pl;
  logic [AW-1:0]       addr_cur, addr_jlo, addr_jhi, addr_lead;
  logic [SAMPLE_W-1:0] rd_cur, rd_jlo, rd_jhi, rd_lead;
  logic [SAMPLE_W-1:0] chain1, chain2;
  logic [SAMPLE_W-1:0] s_q;
  s3d_meta_t           meta, meta_q;
  logic                s1_valid;
  s3d_ops_t            ops;
  logic                res_valid;
  s3d_res_t            res_item;

  s3d_cfg_regs #(
    .MAX_I (MAX_I),
    .MAX_J (MAX_J),
    .MAX_K (MAX_K)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Coordinates of the incoming sample against the effective sizes.
  assign ci = CMP_W'(cnt_i);
  assign cj = CMP_W'(cnt_j);
  assign ck = CMP_W'(cnt_k);
  assign ni = CMP_W'(cfg.n_i);
  assign nj = CMP_W'(cfg.n_j);
  assign nk = CMP_W'(cfg.n_k);

  assign k_end = ck == nk - 1'b1;
  assign j_end = cj == nj - 1'b1;
  assign i_end = ci == ni - 1'b1;

  // The sample at (i,j,k) completes the neighborhood of (i-1,j,k).
  assign emit = (ci >= CMP_W'(2)) && (cj >= CMP_W'(1)) && (cj + CMP_W'(2) <= nj) &&
                (ck >= CMP_W'(1)) && (ck + CMP_W'(2) <= nk);

  assign samples.ready = !rst && can_reserve;
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    meta.pos_i      = POS_W'(ci - 1'b1);
    meta.pos_j      = POS_W'(cj);
    meta.pos_k      = POS_W'(ck);
    meta.last_point = i_end && (cj == nj - CMP_W'(2)) && (ck == nk - CMP_W'(2));
  end

  // Raster counter advance.
  always_comb begin
    k_next = KW'(cnt_k + 1'b1);
    j_next = cnt_j;
    i_next = cnt_i;
    if (k_end) begin
      k_next = '0;
      j_next = JW'(cnt_j + 1'b1);
      if (j_end) begin
        j_next = '0;
        i_next = i_end ? '0 : IW'(cnt_i + 1'b1);
      end
    end
  end

  // Plane memory addresses. The current plane's bank still holds plane i-2
  // at (j,k). The lead read fetches the next raster position of plane i-1;
  // delayed by one and two items it supplies the center and the k-1 neighbor.
  assign cur_pl   = cnt_i[0];
  assign prev_pl  = ~cnt_i[0];
  assign addr_cur = {cur_pl, cnt_j, cnt_k};
  assign addr_jlo = {prev_pl, JW'(cnt_j - 1'b1), cnt_k};
  assign addr_jhi = {prev_pl, JW'(cnt_j + 1'b1), cnt_k};
  assign addr_lead = k_end ? {prev_pl, JW'(cnt_j + 1'b1), KW'(0)}
                           : {prev_pl, cnt_j, KW'(cnt_k + 1'b1)};

  s3d_plane_mem #(
    .AW (AW),
    .DW (SAMPLE_W)
  ) u_mem_a (
    .clk    (clk),
    .we     (accept),
    .waddr  (addr_cur),
    .wdata  (samples.sample),
    .re     (accept),
    .raddr0 (addr_cur),
    .raddr1 (addr_jlo),
    .rdata0 (rd_cur),
    .rdata1 (rd_jlo)
  );

  s3d_plane_mem #(
    .AW (AW),
    .DW (SAMPLE_W)
  ) u_mem_b (
    .clk    (clk),
    .we     (accept),
    .waddr  (addr_cur),
    .wdata  (samples.sample),
    .re     (accept),
    .raddr0 (addr_jhi),
    .raddr1 (addr_lead),
    .rdata0 (rd_jhi),
    .rdata1 (rd_lead)
  );

  // Counters and the read-stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_i    <= '0;
      cnt_j    <= '0;
      cnt_k    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg.restart) begin
        cnt_i <= '0;
        cnt_j <= '0;
        cnt_k <= '0;
      end else if (accept) begin
        cnt_i <= i_next;
        cnt_j <= j_next;
        cnt_k <= k_next;
      end
      s1_valid <= accept && emit;
    end
  end

  // Sample, tag and the two-deep chain of lead reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_q    <= samples.sample;
      meta_q <= meta;
      chain1 <= rd_lead;
      chain2 <= chain1;
    end
  end

  always_comb begin
    ops.center = chain1;
    ops.k_lo   = chain2;
    ops.k_hi   = rd_lead;
    ops.j_lo   = rd_jlo;
    ops.j_hi   = rd_jhi;
    ops.i_lo   = rd_cur;
    ops.i_hi   = s_q;
  end

  s3d_stencil_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .ops       (ops),
    .meta      (meta_q),
    .out_valid (res_valid),
    .out_item  (res_item)
  );

  s3d_out_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .reserve     (accept && emit),
    .push        (res_valid),
    .push_item   (res_item),
    .can_reserve (can_reserve),
    .res         (results)
  );

  `S3D_ASSERT_IMP(a_point_reaches_queue, accept && emit, ##5 res_valid, "interior point lost in pipeline")

endmodule

`default_nettype wire

// ===== tb/stencil_3d_seven_point_tb.sv =====
`timescale 1ns / 1ps

module stencil_3d_seven_point_tb;
  import s3d_pkg::*;

  // Register map of the APB port, one 32-bit word per register.
  typedef enum int {
    REG_SIZE_I = 0,
    REG_SIZE_J = 1,
    REG_SIZE_K = 2,
    REG_UNUSED = 3
  } size_reg_t;

  localparam int LAT_CYCLES = 12;
  localparam int QUIET_LIMIT = 4000;
  localparam int GRID_MAX = DEF_MAX_I;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  s3d_sample_if samples ();
  s3d_result_if results ();

  stencil_3d_seven_point i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Idling controls, changed per test phase.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatch_count = 0;

  // Mirror of the block: size registers, raster counters and the two planes.
  logic [CFG_W-1:0] size_reg [3];
  int unsigned cnt_i;
  int unsigned cnt_j;
  int unsigned cnt_k;
  logic [SAMPLE_W-1:0] plane_mem [2][GRID_MAX][GRID_MAX];
  s3d_res_t expected_points [$];

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Effective extent of an axis: sizes below 3 act as 3, above capacity as capacity.
  function automatic int unsigned extent(input logic [CFG_W-1:0] raw);
    if (raw < 3) return 3;
    if (raw > GRID_MAX) return GRID_MAX;
    return raw;
  endfunction

  // Takes one sample into the grid mirror and returns whether it completes an
  // interior point, whose updated value is then placed in point.
  function automatic bit advance_grid(input logic [SAMPLE_W-1:0] s, output s3d_res_t point);
    int unsigned ni;
    int unsigned nj;
    int unsigned nk;
    int unsigned i;
    int unsigned j;
    int unsigned k;
    int unsigned cur;
    int unsigned prev;
    longint c;
    longint sum;
    longint r;
    bit hit;
    ni = extent(size_reg[REG_SIZE_I]);
    nj = extent(size_reg[REG_SIZE_J]);
    nk = extent(size_reg[REG_SIZE_K]);
    i = cnt_i;
    j = cnt_j;
    k = cnt_k;
    cur = i & 1;
    prev = (i + 1) & 1;
    hit = 1'b0;
    point = '0;
    if (i >= ni) i = ni - 1;
    if (j >= nj) j = nj - 1;
    if (k >= nk) k = nk - 1;

    // The incoming sample closes the neighborhood of the point one plane back.
    if (i >= 2 && j >= 1 && j + 2 <= nj && k >= 1 && k + 2 <= nk) begin
      c = longint'($signed(plane_mem[prev][j][k]));
      sum = longint'($signed(plane_mem[cur][j][k])) + longint'($signed(s))
          + longint'($signed(plane_mem[prev][j-1][k]))
          + longint'($signed(plane_mem[prev][j+1][k]))
          + longint'($signed(plane_mem[prev][j][k-1]))
          + longint'($signed(plane_mem[prev][j][k+1]));
      r = c + (sum - 6 * c) / 6;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      point.result = r[31:0];
      point.pos_i = POS_W'(i - 1);
      point.pos_j = POS_W'(j);
      point.pos_k = POS_W'(k);
      point.last_point = (i - 1 == ni - 2) && (j == nj - 2) && (k == nk - 2);
      hit = 1'b1;
    end
    plane_mem[cur][j][k] = s;

    // Raster order: k fastest, wrapping to a new grid after the last sample.
    k++;
    if (k >= nk) begin
      k = 0;
      j++;
      if (j >= nj) begin
        j = 0;
        i++;
        if (i >= ni) i = 0;
      end
    end
    cnt_i = i;
    cnt_j = j;
    cnt_k = k;
    return hit;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Follows every handshake on the ports: register writes and samples feed the
  // mirror, results are compared against the oldest predicted point.
  always @(posedge clk) begin : scoreboard
    s3d_res_t point;
    s3d_res_t want;
    int unsigned index;
    if (rst) begin
      for (int n = 0; n < 3; n++) size_reg[n] = CFG_W'(GRID_MAX);
      cnt_i = 0;
      cnt_j = 0;
      cnt_k = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        index = paddr >> 2;
        if (index <= REG_SIZE_K) begin
          size_reg[index] = pwdata[CFG_W-1:0];
          cnt_i = 0;
          cnt_j = 0;
          cnt_k = 0;
        end
      end
      if (samples.valid && samples.ready) begin
        if (advance_grid(samples.sample, point)) expected_points.push_back(point);
      end
      if (results.valid && results.ready) begin
        if (expected_points.size() == 0) begin
          $error("result item with nothing predicted: 0x%0h at (%0d,%0d,%0d)",
                 results.result, results.pos_i, results.pos_j, results.pos_k);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("result", want.result, results.result);
          check_field("pos_i", want.pos_i, results.pos_i);
          check_field("pos_j", want.pos_j, results.pos_j);
          check_field("pos_k", want.pos_k, results.pos_k);
          check_field("last_point", want.last_point, results.last_point);
        end
      end
    end
  end

  // Receiver: ready drops at random according to the current stall rate.
  initial begin : result_ready_driver
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      results.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Ends the run if no handshake of any kind happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)
          || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Sends one sample item, with an optional idle gap before it.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.sample <= value;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
  endtask

  // Stops the sample stream and waits until every predicted point is out and
  // the pipeline has had time to finish border samples.
  task automatic drain_pipeline();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then the bus returns to idle.
  task automatic write_register(input size_reg_t index, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(int'(index) * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure_grid(input int ni, input int nj, input int nk);
    drain_pipeline();
    write_register(REG_SIZE_I, ni);
    write_register(REG_SIZE_J, nj);
    write_register(REG_SIZE_K, nk);
  endtask

  // Mostly full-range values, with the extremes and small values near zero
  // that make the truncating division round toward zero.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int near_zero;
    near_zero = int'($urandom_range(12)) - 6;
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return near_zero;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_sample(rand_sample());
  endtask

  // Smallest grid: one interior point with the most negative center and the
  // most positive neighbors; the border walks zero, all ones and single bits.
  task automatic test_extreme_samples();
    logic [SAMPLE_W-1:0] value;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    configure_grid(3, 3, 3);
    for (int n = 0; n < 27; n++) begin
      if (n == 13) begin
        value = 32'h8000_0000;
      end else if (n == 4 || n == 10 || n == 12 || n == 14 || n == 16 || n == 22) begin
        value = 32'h7FFF_FFFF;
      end else begin
        case (n % 4)
          0: value = 32'h0000_0000;
          1: value = 32'hFFFF_FFFF;
          2: value = 32'h1 << n;
          default: value = ~(32'h1 << n);
        endcase
      end
      send_sample(value);
    end
  endtask

  // Sizes outside 3..64 are clamped, and only the low 7 bits of a write count.
  task automatic test_size_clamp();
    src_idle_pct = 15;
    sink_stall_pct = 15;
    drain_pipeline();
    write_register(REG_SIZE_I, 32'hFFFF_FF7F);
    write_register(REG_SIZE_J, 32'h0000_0180);
    write_register(REG_SIZE_K, 32'h0000_0002);
    send_random(64 * 3 * 3);
    drain_pipeline();
    write_register(REG_SIZE_I, 32'h0000_0001);
    write_register(REG_SIZE_J, 32'h0000_0041);
    write_register(REG_SIZE_K, 32'h0000_0003);
  endtask

  // A size write restarts the grid mid-way, a write to the unused address does
  // not, and a finished grid wraps straight into the next one.
  task automatic test_restart_and_wrap();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    configure_grid(3, 3, 4);
    send_random(30);
    drain_pipeline();
    write_register(REG_SIZE_K, 4);
    send_random(36);
    send_random(10);
    drain_pipeline();
    write_register(REG_UNUSED, $urandom);
    send_random(26);
    send_random(36);
  endtask

  // Random grid shapes under one idling setting; the first grid may stretch
  // one axis to full capacity, and some grids are cut short by a new size.
  task automatic test_random_grids(input int src_pct, input int sink_pct, input int budget,
                                   input int wide_axis);
    int sent;
    int ni;
    int nj;
    int nk;
    int count;
    bit first;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    first = 1'b1;
    while (sent < budget) begin
      ni = $urandom_range(3, 5);
      nj = $urandom_range(3, 6);
      nk = $urandom_range(3, 8);
      if (first && wide_axis >= 0) begin
        ni = (wide_axis == REG_SIZE_I) ? GRID_MAX : 3;
        nj = (wide_axis == REG_SIZE_J) ? GRID_MAX : 3;
        nk = (wide_axis == REG_SIZE_K) ? GRID_MAX : 3;
      end
      count = ni * nj * nk;
      if (!first && $urandom_range(4) == 0) count = $urandom_range(1, count - 1);
      configure_grid(ni, nj, nk);
      send_random(count);
      sent += count;
      first = 1'b0;
    end
  endtask

  initial begin
    rst <= 1'b1;
    samples.valid <= 1'b0;
    samples.sample <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < GRID_MAX; b++)
        for (int c = 0; c < GRID_MAX; c++) plane_mem[a][b][c] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extreme_samples();
    test_size_clamp();
    test_restart_and_wrap();
    test_random_grids(0, 0, 30, -1);
    test_random_grids(66, 0, 576, REG_SIZE_J);
    test_random_grids(0, 66, 576, REG_SIZE_K);
    test_random_grids(15, 15, 30, -1);

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
